>>> hw/rtl/icsp_pkg.sv
// ----------------------------------------------------------------------------
// icsp_pkg
// Shared types and constants of the interval-cover shortest path unit.
// ----------------------------------------------------------------------------
package icsp_pkg;

   localparam int unsigned MAX_POINTS_DEF    = 1024;
   localparam int unsigned MAX_INTERVALS_DEF = 1024;

   localparam int unsigned PT_W   = 10;
   localparam int unsigned COST_W = 32;
   localparam int unsigned DIST_W = 48;
   localparam int unsigned CFG_W  = 11;
   localparam logic [CFG_W-1:0] NUM_POINTS_RST = 11'd1024;

   localparam int unsigned CSR_ADDR_W = 3;
   localparam logic [CSR_ADDR_W-1:0] REG_NUM_POINTS = 3'd0;

   typedef struct packed {
      logic [COST_W-1:0] cost;
      logic [PT_W-1:0]   right;
      logic [PT_W-1:0]   left;
   } interval_type;

   typedef struct packed {
      logic              known;
      logic              settled;
      logic [DIST_W-1:0] dist_val;
   } node_type;

   typedef struct packed {
      logic              reachable;
      logic [DIST_W-1:0] min_cost;
   } result_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_CLEAR,
      S_SCAN,
      S_SETTLE,
      S_PREV_RD,
      S_PREV_UPD,
      S_IV_RD,
      S_IV_CHK,
      S_DST_UPD,
      S_DONE
   } state_type;

endpackage

>>> hw/rtl/icsp_imem.sv
// ----------------------------------------------------------------------------
// icsp_imem
// Interval store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module icsp_imem #(
   parameter int unsigned DEPTH = icsp_pkg::MAX_INTERVALS_DEF,
   parameter int unsigned AW    = 10
) (
   input  logic                   clock,
   input  logic                   wr_en,
   input  logic [AW-1:0]          wr_addr,
   input  icsp_pkg::interval_type wr_data,
   input  logic [AW-1:0]          rd_addr,
   output icsp_pkg::interval_type rd_data
);
   import icsp_pkg::*;

   interval_type mem [DEPTH];
   interval_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/icsp_search.sv
// ----------------------------------------------------------------------------
// icsp_search
// Distance store and search sequencer: clear, minimum scan, settle, relax.
// ----------------------------------------------------------------------------
module icsp_search #(
   parameter int unsigned MAX_POINTS    = icsp_pkg::MAX_POINTS_DEF,
   parameter int unsigned PW            = 10,
   parameter int unsigned NW            = 11,
   parameter int unsigned IAW           = 10,
   parameter int unsigned IW            = 11
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [NW-1:0]          num_pts,
   input  logic [IW-1:0]          iv_count,
   output logic [IAW-1:0]         iv_addr,
   input  icsp_pkg::interval_type iv_data,
   input  logic                   res_free,
   output logic                   res_valid,
   output icsp_pkg::result_type   res,
   output logic                   busy
);
   import icsp_pkg::*;

   node_type        mem [MAX_POINTS];
   node_type        rd_ff;
   logic [PW-1:0]   rd_addr;
   logic            we;
   logic [PW-1:0]   wa;
   node_type        wd;

   state_type         state_ff, state_in;
   logic [NW-1:0]     p_ff, p_in;
   logic [PW-1:0]     sidx_ff, sidx_in;
   logic              pend_ff, pend_in;
   logic              found_ff, found_in;
   logic [PW-1:0]     u_ff, u_in;
   logic [DIST_W-1:0] du_ff, du_in;
   logic [IW-1:0]     i_ff, i_in;
   logic [PW-1:0]     r_ff, r_in;
   logic [DIST_W-1:0] cand_ff, cand_in;
   logic [NW-1:0]     target;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[wa] <= wd;
      end
      rd_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         pend_ff  <= pend_in;
      end
      p_ff     <= p_in;
      sidx_ff  <= sidx_in;
      found_ff <= found_in;
      u_ff     <= u_in;
      du_ff    <= du_in;
      i_ff     <= i_in;
      r_ff     <= r_in;
      cand_ff  <= cand_in;
   end

   assign target = num_pts - NW'(1);
   assign busy   = (state_ff != S_IDLE);
   assign iv_addr = i_ff[IAW-1:0];

   always_comb begin
      state_in  = state_ff;
      p_in      = p_ff;
      sidx_in   = sidx_ff;
      pend_in   = 1'b0;
      found_in  = found_ff;
      u_in      = u_ff;
      du_in     = du_ff;
      i_in      = i_ff;
      r_in      = r_ff;
      cand_in   = cand_ff;
      rd_addr   = p_ff[PW-1:0];
      we        = 1'b0;
      wa        = p_ff[PW-1:0];
      wd        = '0;
      res_valid = 1'b0;
      res       = '0;
      unique case (state_ff)
         S_IDLE: begin
            p_in = '0;
            if (start) begin
               state_in = S_CLEAR;
            end
         end
         S_CLEAR: begin
            we         = 1'b1;
            wd.known   = (p_ff == '0);
            p_in       = p_ff + NW'(1);
            if (p_in == num_pts) begin
               state_in = S_SCAN;
               p_in     = '0;
               found_in = 1'b0;
            end
         end
         S_SCAN: begin
            if (pend_ff && rd_ff.known && !rd_ff.settled &&
                (!found_ff || rd_ff.dist_val < du_ff)) begin
               found_in = 1'b1;
               u_in     = sidx_ff;
               du_in    = rd_ff.dist_val;
            end
            if (p_ff < num_pts) begin
               pend_in = 1'b1;
               sidx_in = p_ff[PW-1:0];
               p_in    = p_ff + NW'(1);
            end else if (!pend_ff) begin
               state_in = S_SETTLE;
            end
         end
         S_SETTLE: begin
            i_in = '0;
            if (!found_ff) begin
               state_in = S_DONE;
            end else begin
               we          = 1'b1;
               wa          = u_ff;
               wd.known    = 1'b1;
               wd.settled  = 1'b1;
               wd.dist_val = du_ff;
               if (NW'(u_ff) == target) begin
                  state_in = S_DONE;
               end else if (u_ff != '0) begin
                  state_in = S_PREV_RD;
               end else if (iv_count != '0) begin
                  state_in = S_IV_RD;
               end else begin
                  state_in = S_SCAN;
                  p_in     = '0;
                  found_in = 1'b0;
               end
            end
         end
         S_PREV_RD: begin
            rd_addr  = u_ff - PW'(1);
            r_in     = u_ff - PW'(1);
            cand_in  = du_ff;
            state_in = S_PREV_UPD;
         end
         S_PREV_UPD, S_DST_UPD: begin
            if (!rd_ff.settled && (!rd_ff.known || cand_ff < rd_ff.dist_val)) begin
               we          = 1'b1;
               wa          = r_ff;
               wd.known    = 1'b1;
               wd.dist_val = cand_ff;
            end
            if (state_ff == S_PREV_UPD) begin
               i_in = '0;
               if (iv_count != '0) begin
                  state_in = S_IV_RD;
               end else begin
                  state_in = S_SCAN;
                  p_in     = '0;
                  found_in = 1'b0;
               end
            end else begin
               i_in = i_ff + IW'(1);
               if (i_in < iv_count) begin
                  state_in = S_IV_RD;
               end else begin
                  state_in = S_SCAN;
                  p_in     = '0;
                  found_in = 1'b0;
               end
            end
         end
         S_IV_RD: begin
            state_in = S_IV_CHK;
         end
         S_IV_CHK: begin
            if (iv_data.left == PT_W'(u_ff) && NW'(iv_data.right) < num_pts &&
                32'(iv_data.left) == 32'(u_ff)) begin
               rd_addr  = PW'(iv_data.right);
               r_in     = PW'(iv_data.right);
               cand_in  = du_ff + DIST_W'(iv_data.cost);
               state_in = S_DST_UPD;
            end else begin
               i_in = i_ff + IW'(1);
               if (i_in < iv_count) begin
                  state_in = S_IV_RD;
               end else begin
                  state_in = S_SCAN;
                  p_in     = '0;
                  found_in = 1'b0;
               end
            end
         end
         S_DONE: begin
            if (res_free) begin
               res_valid     = 1'b1;
               res.reachable = found_ff;
               res.min_cost  = found_ff ? du_ff : '0;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

>>> hw/rtl/interval_cover_shortest_path_unit.sv
// ----------------------------------------------------------------------------
// interval_cover_shortest_path_unit
// Loads weighted intervals, then finds the least cost from point 0 to the
// last point by a settle-and-relax search over a distance store.
// ----------------------------------------------------------------------------
//  channel | dir | tdata / data                         | tuser     | tlast
//  req_    | in  | left[9:0] right[19:10] cost[51:20]   | -         | last
//  rsp_    | out | min_cost[47:0]                       | reachable | -
//  csr_    | in  | num_points at byte address 0         | -         | -
//
//  Loading takes one item per cycle while no search runs. After the last item
//  the search runs: clearing, then per settled point a scan and a settle, a
//  relax of the point below and a check of each stored interval.
//  Scan, relax and clear all share the one port pair of the distance store.
//  req_tready is low during the search; reset is synchronous and empties
//  the interval store. A waiting result does not block new loading.
// ----------------------------------------------------------------------------
module interval_cover_shortest_path_unit #(
   parameter int unsigned MAX_POINTS    = icsp_pkg::MAX_POINTS_DEF,
   parameter int unsigned MAX_INTERVALS = icsp_pkg::MAX_INTERVALS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [55:0]                       req_tdata,   // left, right, cost
   input  logic                              req_tlast,   // last
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [47:0]                       rsp_tdata,   // min_cost
   output logic                              rsp_tuser,   // reachable
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [icsp_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [31:0]                       csr_pwdata,
   output logic [31:0]                       csr_prdata,
   output logic                              csr_pready
);
   import icsp_pkg::*;

   localparam int unsigned PW  = $clog2(MAX_POINTS);
   localparam int unsigned NW  = $clog2(MAX_POINTS + 1);
   localparam int unsigned IAW = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;
   localparam int unsigned IW  = $clog2(MAX_INTERVALS + 1);

   logic [CFG_W-1:0] num_points_ff;
   logic [IW-1:0]    count_ff, count_in;
   logic             rsp_valid_ff, rsp_valid_in;
   result_type       rsp_ff, rsp_in;
   logic [NW-1:0]    n_eff;
   logic             acc, start, busy, res_valid, res_free;
   interval_type     wdata, iv_data;
   logic [IAW-1:0]   iv_addr;
   result_type       res;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == REG_NUM_POINTS) ? 32'(num_points_ff) : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         num_points_ff <= NUM_POINTS_RST;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
                   csr_paddr == REG_NUM_POINTS) begin
         num_points_ff <= csr_pwdata[CFG_W-1:0];
      end
   end

   always_comb begin
      if (num_points_ff == '0) begin
         n_eff = NW'(1);
      end else if (32'(num_points_ff) > 32'(MAX_POINTS)) begin
         n_eff = NW'(MAX_POINTS);
      end else begin
         n_eff = NW'(num_points_ff);
      end
   end

   assign req_tready  = !busy;
   assign acc         = req_tvalid && req_tready;
   assign start       = acc && req_tlast;
   assign wdata.left  = req_tdata[PT_W-1:0];
   assign wdata.right = req_tdata[2*PT_W-1:PT_W];
   assign wdata.cost  = req_tdata[2*PT_W+COST_W-1:2*PT_W];
   assign res_free    = !rsp_valid_ff || rsp_tready;

   always_comb begin
      count_in = count_ff;
      if (acc && 32'(count_ff) < 32'(MAX_INTERVALS)) begin
         count_in = count_ff + IW'(1);
      end
      if (res_valid) begin
         count_in = '0;
      end
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_in       = rsp_ff;
      if (res_valid) begin
         rsp_valid_in = 1'b1;
         rsp_in       = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_ff.min_cost;
   assign rsp_tuser  = rsp_ff.reachable;

   icsp_imem #(
      .DEPTH (MAX_INTERVALS),
      .AW    (IAW)
   ) u_imem (
      .clock   (clock),
      .wr_en   (acc && 32'(count_ff) < 32'(MAX_INTERVALS)),
      .wr_addr (count_ff[IAW-1:0]),
      .wr_data (wdata),
      .rd_addr (iv_addr),
      .rd_data (iv_data)
   );

   icsp_search #(
      .MAX_POINTS    (MAX_POINTS),
      .PW            (PW),
      .NW            (NW),
      .IAW           (IAW),
      .IW            (IW)
   ) u_search (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .num_pts   (n_eff),
      .iv_count  (count_ff),
      .iv_addr   (iv_addr),
      .iv_data   (iv_data),
      .res_free  (res_free),
      .res_valid (res_valid),
      .res       (res),
      .busy      (busy)
   );

endmodule

>>> hw/rtl/icsp_checker.sv
// ----------------------------------------------------------------------------
// icsp_checker
// Port-level checks of the interval-cover shortest path unit.
// ----------------------------------------------------------------------------
module icsp_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        req_tlast,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [47:0] rsp_tdata,
   input logic        rsp_tuser
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result item dropped or changed while stalled");

   a_unreach_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata == 48'd0)
      else $error("unreachable result carries a cost");

   a_search_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tlast |=> !req_tready)
      else $error("item taken while search runs");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result after reset");

endmodule

bind interval_cover_shortest_path_unit icsp_checker u_icsp_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tlast  (req_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
